// ----- design/laser_command_frame_encoder_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the laser command frame encoder
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef LASER_COMMAND_FRAME_ENCODER_ASSERT_SVH
`define LASER_COMMAND_FRAME_ENCODER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define LCFE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define LCFE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/lcfe_pkg.sv -----
// ---------------------------------------------------------------------------
// lcfe_pkg
// Types and codes shared by the laser command frame encoder modules.
// ---------------------------------------------------------------------------
package lcfe_pkg;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] value;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic [1:0] status;
  } out_t;

  // command kinds
  localparam logic [2:0] KIND_LEVEL = 3'd0;
  localparam logic [2:0] KIND_FREQ  = 3'd1;
  localparam logic [2:0] KIND_PULSE = 3'd2;
  localparam logic [2:0] KIND_EXT   = 3'd3;
  localparam logic [2:0] KIND_INT   = 3'd4;
  localparam logic [2:0] KIND_OFF   = 3'd5;

  // result status
  localparam logic [1:0] ST_SENT  = 2'd0;
  localparam logic [1:0] ST_LEVEL = 2'd1;
  localparam logic [1:0] ST_EXT   = 2'd2;

  localparam int HDR_W = 40;  // function byte + 4 data bytes

  // decoded command waiting for the serializer
  typedef struct packed {
    logic             rej;
    logic [1:0]       status;
    logic [HDR_W-1:0] hdr;
  } pend_t;

endpackage

// ----- design/laser_command_frame_encoder.sv -----
// ---------------------------------------------------------------------------
// laser_command_frame_encoder
// Turns laser commands into 7-byte frames with a CRC-16/MODBUS trailer.
// ---------------------------------------------------------------------------
// Input channel (in_valid/in_stall/in_data): one command item, kind + value.
// Output channel (out_valid/out_stall/out_data): one frame byte per item,
// function byte, 4 data bytes big-endian, CRC low then high; last marks
// the seventh byte. A rejected command (level outside 1..200, or frequency
// while in external-trigger mode) yields a single item with byte 0, last
// set and a nonzero status. Kinds 6 and 7 produce nothing.
// After a command is accepted, its first byte passes through the command
// register and then the output register.
// Throughput: one rejection per cycle while out_stall is low; the rate is
// set by the single output byte register, which emits one byte a cycle when not stalled.
// The CRC is folded in one byte per unstalled cycle as header bytes pass through.
// A one-entry command register sits ahead of the serializer, so the next
// command is taken while the current frame is still being sent.
// Reset clears the trigger mode to internal and empties both stages.
// When out_stall is high the output item holds and the serializer waits;
// in_stall is high while the command register is full and not being taken.
// ---------------------------------------------------------------------------
module laser_command_frame_encoder (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  lcfe_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output lcfe_pkg::out_t out_data
);
  import lcfe_pkg::*;

  logic  pend_valid;
  pend_t pend;
  logic  take;

  lcfe_cmd u_cmd (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .take       (take),
    .pend_valid (pend_valid),
    .pend       (pend)
  );

  lcfe_ser u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .pend_valid (pend_valid),
    .pend       (pend),
    .take       (take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

// ----- design/lcfe_cmd.sv -----
// ---------------------------------------------------------------------------
// lcfe_cmd
// Command decode and holding register; tracks the trigger mode.
// ---------------------------------------------------------------------------
module lcfe_cmd (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  lcfe_pkg::in_t in_data,
  input  logic          take,
  output logic          pend_valid,
  output lcfe_pkg::pend_t pend
);
  import lcfe_pkg::*;

  localparam logic [7:0] FN_LEVEL = 8'h01;
  localparam logic [7:0] FN_FREQ  = 8'h02;
  localparam logic [7:0] FN_PULSE = 8'h03;
  localparam logic [7:0] FN_TRIG  = 8'h04;
  localparam logic [7:0] LEVEL_MAX = 8'd200;

  logic  ext_mode_r, ext_mode_nxt;
  logic  pend_valid_r, pend_valid_nxt;
  pend_t pend_r, pend_nxt;
  logic  acc;
  logic [7:0] lvl;

  assign in_stall   = pend_valid_r && !take;
  assign acc        = in_valid && !in_stall;
  assign lvl        = in_data.value[7:0];
  assign pend_valid = pend_valid_r;
  assign pend       = pend_r;

  always_comb begin
    ext_mode_nxt   = ext_mode_r;
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r && !take;
    if (acc) begin
      pend_nxt.rej    = 1'b0;
      pend_nxt.status = ST_SENT;
      pend_valid_nxt  = 1'b1;
      case (in_data.kind)
        KIND_LEVEL: begin
          if (lvl == 8'd0 || lvl > LEVEL_MAX) begin
            pend_nxt.rej    = 1'b1;
            pend_nxt.status = ST_LEVEL;
          end
          pend_nxt.hdr = {FN_LEVEL, 24'd0, lvl};
        end
        KIND_FREQ: begin
          if (ext_mode_r) begin
            pend_nxt.rej    = 1'b1;
            pend_nxt.status = ST_EXT;
          end
          pend_nxt.hdr = {FN_FREQ, in_data.value};
        end
        KIND_PULSE: pend_nxt.hdr = {FN_PULSE, 24'd0, lvl};
        KIND_EXT: begin
          pend_nxt.hdr = {FN_TRIG, 32'd2};
          ext_mode_nxt = 1'b1;
        end
        KIND_INT: begin
          pend_nxt.hdr = {FN_TRIG, 32'd1};
          ext_mode_nxt = 1'b0;
        end
        KIND_OFF: pend_nxt.hdr = {FN_TRIG, 32'd0};
        default: begin
          // undefined kinds are dropped without a result
          pend_nxt       = pend_r;
          pend_valid_nxt = pend_valid_r && !take;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_mode_r   <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      ext_mode_r   <= ext_mode_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
  end

endmodule

// ----- design/lcfe_ser.sv -----
// ---------------------------------------------------------------------------
// lcfe_ser
// Frame serializer: one byte per cycle into the output register while not
// stalled, CRC accumulated a byte at a time as the header bytes go out.
// ---------------------------------------------------------------------------
module lcfe_ser (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            pend_valid,
  input  lcfe_pkg::pend_t pend,
  output logic            take,
  output logic            out_valid,
  input  logic            out_stall,
  output lcfe_pkg::out_t  out_data
);
  import lcfe_pkg::*;

  `include "laser_command_frame_encoder_assert.svh"

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [2:0]  CRC_LO_IDX = 3'd5;
  localparam logic [2:0]  LAST_IDX   = 3'd6;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  logic             busy_r, busy_nxt;
  logic [2:0]       idx_r, idx_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [HDR_W-1:0] hdr_r, hdr_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_r, out_nxt;

  logic             advance, have;
  logic [HDR_W-1:0] cur_hdr;
  logic [2:0]       cur_idx;
  logic [15:0]      cur_crc;
  logic [7:0]       cur_byte;

  assign advance   = !out_valid_r || !out_stall;
  assign have      = busy_r || pend_valid;
  assign take      = advance && !busy_r && pend_valid;
  assign cur_hdr   = busy_r ? hdr_r : pend.hdr;
  assign cur_idx   = busy_r ? idx_r : 3'd0;
  assign cur_crc   = busy_r ? crc_r : CRC_INIT;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    case (cur_idx)
      3'd0:    cur_byte = cur_hdr[39:32];
      3'd1:    cur_byte = cur_hdr[31:24];
      3'd2:    cur_byte = cur_hdr[23:16];
      3'd3:    cur_byte = cur_hdr[15:8];
      3'd4:    cur_byte = cur_hdr[7:0];
      3'd5:    cur_byte = cur_crc[7:0];
      3'd6:    cur_byte = cur_crc[15:8];
      default: cur_byte = 8'd0;
    endcase
  end

  always_comb begin
    busy_nxt      = busy_r;
    idx_nxt       = idx_r;
    crc_nxt       = crc_r;
    hdr_nxt       = hdr_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (advance) begin
      out_valid_nxt = have;
      if (have) begin
        if (!busy_r && pend.rej) begin
          out_nxt.out_byte = 8'd0;
          out_nxt.last     = 1'b1;
          out_nxt.status   = pend.status;
        end else begin
          out_nxt.out_byte = cur_byte;
          out_nxt.last     = (cur_idx == LAST_IDX);
          out_nxt.status   = ST_SENT;
          busy_nxt         = (cur_idx != LAST_IDX);
          idx_nxt          = cur_idx + 3'd1;
          hdr_nxt          = cur_hdr;
          crc_nxt          = (cur_idx < CRC_LO_IDX) ? crc_byte(cur_crc, cur_byte) : cur_crc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    crc_r <= crc_nxt;
    hdr_r <= hdr_nxt;
    out_r <= out_nxt;
  end

  `LCFE_ASSERT_SAME(a_rej_shape, out_valid_r && (out_r.status != ST_SENT),
                    out_r.last && (out_r.out_byte == 8'd0), "rejection item malformed")
  `LCFE_ASSERT_SAME(a_busy_idx, busy_r, (idx_r != 3'd0) && (idx_r <= LAST_IDX),
                    "serializer index out of frame")
  `LCFE_ASSERT_NEXT(a_frame_end, advance && busy_r && (idx_r == LAST_IDX),
                    out_valid_r && out_r.last && !busy_r, "frame did not end on byte seven")
  `LCFE_ASSERT_NEXT(a_rej_single, take && pend.rej,
                    out_valid_r && out_r.last && !busy_r, "rejection not a single item")

endmodule

// ----- verif/tb_laser_command_frame_encoder.sv -----
// ---------------------------------------------------------------------------
// tb_laser_command_frame_encoder
// Self-checking bench: a directed command table, then random commands.
// Every accepted command is run through a local frame/CRC predictor and the
// output bytes are matched in order. Both sides idle and stall at random.
// ---------------------------------------------------------------------------
module tb_laser_command_frame_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  import lcfe_pkg::*;

  localparam logic [2:0] KIND_RSVD6 = 3'd6;
  localparam logic [2:0] KIND_RSVD7 = 3'd7;

  localparam logic [7:0]  FN_LEVEL   = 8'h01;
  localparam logic [7:0]  FN_FREQ    = 8'h02;
  localparam logic [7:0]  FN_PULSE   = 8'h03;
  localparam logic [7:0]  FN_TRIGGER = 8'h04;
  localparam logic [31:0] TRIG_EXT   = 32'd2;
  localparam logic [31:0] TRIG_INT   = 32'd1;
  localparam logic [31:0] TRIG_OFF   = 32'd0;
  localparam logic [7:0]  LEVEL_MAX  = 8'd200;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;

  localparam int FRAME_BYTES  = 7;
  localparam int RAND_CMDS    = 150;
  localparam int DRAIN_CYCLES = 20;
  localparam int STALL_LIMIT  = 2000;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] value;
    logic        rej;      // expected result typed in: a single rejection
    logic [1:0]  status;
  } cmd_row_t;

  localparam int N_ROWS = 24;
  cmd_row_t cmd_table [N_ROWS] = '{
    '{KIND_LEVEL, 32'h0000_0000, 1'b1, ST_LEVEL},
    '{KIND_LEVEL, 32'h0000_0001, 1'b0, ST_SENT},
    '{KIND_LEVEL, 32'h0000_00C8, 1'b0, ST_SENT},
    '{KIND_LEVEL, 32'h0000_00C9, 1'b1, ST_LEVEL},
    '{KIND_LEVEL, 32'h0000_00FF, 1'b1, ST_LEVEL},
    '{KIND_LEVEL, 32'hFFFF_FF01, 1'b0, ST_SENT},
    '{KIND_LEVEL, 32'h0000_0100, 1'b1, ST_LEVEL},
    '{KIND_FREQ,  32'h0000_0000, 1'b0, ST_SENT},
    '{KIND_FREQ,  32'hFFFF_FFFF, 1'b0, ST_SENT},
    '{KIND_PULSE, 32'h0000_0000, 1'b0, ST_SENT},
    '{KIND_PULSE, 32'hFFFF_FFFF, 1'b0, ST_SENT},
    '{KIND_OFF,   32'h0000_0000, 1'b0, ST_SENT},
    '{KIND_EXT,   32'h0000_0000, 1'b0, ST_SENT},
    '{KIND_FREQ,  32'h0000_03E8, 1'b1, ST_EXT},
    '{KIND_OFF,   32'hFFFF_FFFF, 1'b0, ST_SENT},
    '{KIND_EXT,   32'hA5A5_A5A5, 1'b0, ST_SENT},
    '{KIND_FREQ,  32'hFFFF_FFFF, 1'b1, ST_EXT},
    '{KIND_LEVEL, 32'h0000_0000, 1'b1, ST_LEVEL},
    '{KIND_INT,   32'h0000_0000, 1'b0, ST_SENT},
    '{KIND_FREQ,  32'h1234_5678, 1'b0, ST_SENT},
    '{KIND_RSVD6, 32'h0000_0000, 1'b0, ST_SENT},
    '{KIND_RSVD7, 32'hFFFF_FFFF, 1'b0, ST_SENT},
    '{KIND_INT,   32'h5A5A_5A5A, 1'b0, ST_SENT},
    '{KIND_LEVEL, 32'h0000_0040, 1'b0, ST_SENT}
  };

  logic clk;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  laser_command_frame_encoder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // predictor state and result stores
  logic ext_mode = 1'b0;
  out_t frame_q [$];          // bytes of the command just encoded
  out_t pending_bytes_q [$];  // bytes still owed by the block
  int   fail_cnt = 0;

  function automatic logic [15:0] crc16_modbus_byte(logic [15:0] crc, logic [7:0] b);
    int k;
    crc = crc ^ {8'h00, b};
    for (k = 0; k < 8; k++) begin
      crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
    end
    return crc;
  endfunction

  // fills frame_q with the bytes that command c causes; tracks trigger mode
  function automatic void encode_command(in_t c);
    logic [7:0]  fn;
    logic [31:0] data;
    logic [7:0]  hdr [5];
    logic [15:0] crc;
    int          i;
    frame_q.delete();
    case (c.kind)
      KIND_LEVEL: begin
        if (c.value[7:0] == 8'd0 || c.value[7:0] > LEVEL_MAX) begin
          frame_q.push_back('{out_byte: 8'h00, last: 1'b1, status: ST_LEVEL});
          return;
        end
        fn = FN_LEVEL;
        data = {24'h0, c.value[7:0]};
      end
      KIND_FREQ: begin
        if (ext_mode) begin
          frame_q.push_back('{out_byte: 8'h00, last: 1'b1, status: ST_EXT});
          return;
        end
        fn = FN_FREQ;
        data = c.value;
      end
      KIND_PULSE: begin
        fn = FN_PULSE;
        data = {24'h0, c.value[7:0]};
      end
      KIND_EXT: begin
        fn = FN_TRIGGER;
        data = TRIG_EXT;
        ext_mode = 1'b1;
      end
      KIND_INT: begin
        fn = FN_TRIGGER;
        data = TRIG_INT;
        ext_mode = 1'b0;
      end
      KIND_OFF: begin
        fn = FN_TRIGGER;
        data = TRIG_OFF;
      end
      default: return;
    endcase
    hdr[0] = fn;
    hdr[1] = data[31:24];
    hdr[2] = data[23:16];
    hdr[3] = data[15:8];
    hdr[4] = data[7:0];
    crc = CRC_INIT;
    for (i = 0; i < 5; i++) begin
      crc = crc16_modbus_byte(crc, hdr[i]);
      frame_q.push_back('{out_byte: hdr[i], last: 1'b0, status: ST_SENT});
    end
    frame_q.push_back('{out_byte: crc[7:0], last: 1'b0, status: ST_SENT});
    frame_q.push_back('{out_byte: crc[15:8], last: 1'b1, status: ST_SENT});
  endfunction

  // ---- command side ----
  bit tx_idle_on = 1'b1;

  task automatic send_command(in_t c, bit rej, logic [1:0] rej_status);
    int gap;
    if ($urandom_range(0, 24) == 0) tx_idle_on = !tx_idle_on;
    gap = tx_idle_on ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) begin
        in_data = {3'($urandom), $urandom};  // noise while idle
        @(negedge clk);
      end
    end
    in_valid = 1'b1;
    in_data  = c;
    do @(posedge clk); while (in_stall);
    encode_command(c);
    if (rej) begin
      pending_bytes_q.push_back('{out_byte: 8'h00, last: 1'b1, status: rej_status});
    end else begin
      foreach (frame_q[i]) pending_bytes_q.push_back(frame_q[i]);
    end
    @(negedge clk);
  endtask

  function automatic in_t random_command();
    in_t c;
    int  r;
    r = $urandom_range(0, 99);
    c.value = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 300) : $urandom;
    if (r < 4)       c.kind = r[0] ? KIND_RSVD6 : KIND_RSVD7;
    else if (r < 30) c.kind = KIND_LEVEL;
    else if (r < 55) c.kind = KIND_FREQ;
    else if (r < 70) c.kind = KIND_PULSE;
    else if (r < 81) c.kind = KIND_EXT;
    else if (r < 92) c.kind = KIND_INT;
    else             c.kind = KIND_OFF;
    // mostly legal levels, random upper bits kept
    if (c.kind == KIND_LEVEL && $urandom_range(0, 9) < 7) begin
      c.value[7:0] = 8'($urandom_range(1, LEVEL_MAX));
    end
    return c;
  endfunction

  initial begin
    in_t c;
    int  sent;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (int r = 0; r < N_ROWS; r++) begin
      c.kind  = cmd_table[r].kind;
      c.value = cmd_table[r].value;
      send_command(c, cmd_table[r].rej, cmd_table[r].status);
    end

    sent = 0;
    while (sent < RAND_CMDS) begin
      c = random_command();
      send_command(c, 1'b0, ST_SENT);
      if (c.kind != KIND_RSVD6 && c.kind != KIND_RSVD7) sent++;
    end
    in_valid = 1'b0;

    wait (pending_bytes_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // ---- result side ----
  bit   rx_idle_on = 1'b1;
  int   rx_wait    = 0;
  out_t exp_byte;

  always @(negedge clk) begin
    if (rx_wait > 0) begin
      out_stall <= 1'b1;
      rx_wait = rx_wait - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if ($urandom_range(0, 29) == 0) rx_idle_on = !rx_idle_on;
      rx_wait = rx_idle_on ? $urandom_range(0, 18) : 0;
      if (pending_bytes_q.size() == 0) begin
        $error("unexpected result item: out_byte %02h last %0b status %0d",
               out_data.out_byte, out_data.last, out_data.status);
        fail_cnt++;
      end else begin
        exp_byte = pending_bytes_q.pop_front();
        if (out_data.out_byte !== exp_byte.out_byte) begin
          $error("out_byte: expected %02h, actual %02h", exp_byte.out_byte, out_data.out_byte);
          fail_cnt++;
        end
        if (out_data.last !== exp_byte.last) begin
          $error("last: expected %0b, actual %0b", exp_byte.last, out_data.last);
          fail_cnt++;
        end
        if (out_data.status !== exp_byte.status) begin
          $error("status: expected %0d, actual %0d", exp_byte.status, out_data.status);
          fail_cnt++;
        end
      end
    end
  end

  // ---- watchdog: cycles in a row with no item moving on either side ----
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule
